// ===== rtl/core/cshuf_pkg.sv =====
// Shared constants and types for the channel shuffle / requantization block.
// Used by the controller, the datapath and the top level; depends on nothing.
package cshuf_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int ADDR_W       = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = ADDR_W + 1;

    localparam int GRP_W   = 7;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 2;
    localparam int WORD_W  = 32;
    localparam int SCALE_W = 20;
    localparam int OFFS_W  = 28;
    localparam int FRAC_W  = 20;

    localparam logic [IDX_W-1:0] REG_GROUP_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_GROUP_DEPTH = 2'd1;
    localparam logic [IDX_W-1:0] REG_BYTE_MODE   = 2'd2;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic emit_init;
        logic read;
        logic cfg_write;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic pixel_done;
        logic last_read;
    } status_t;

endpackage

// ===== rtl/core/cshuf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cshuf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/cshuf_ctrl.sv =====
// Controller: idle/emit state machine, issues commands to the datapath.
// Depends on cshuf_pkg.
module cshuf_ctrl
    import cshuf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    cfg_valid,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    cfg_ready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.emit_init = 1'b0;
        cmd.read      = 1'b0;
        cmd.cfg_write = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.cfg_write = cfg_valid;
                cmd.accept    = start;
                if (start && status.pixel_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.read = 1'b1;
                if (status.last_read)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

endmodule

// ===== rtl/core/cshuf_dp.sv =====
// Datapath: config registers, requantizer, pixel buffer and transposed read walk.
// Depends on cshuf_pkg and cshuf_ram.
module cshuf_dp
    import cshuf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic signed [WORD_W-1:0] in_value,
    input  logic [SCALE_W-1:0]       requant_scale,
    input  logic [OFFS_W-1:0]        requant_offset,
    input  logic                     requant_bypass,
    output logic                     out_valid,
    output logic signed [WORD_W-1:0] out_value,
    output logic                     last_of_pixel
);

    localparam int PROD_W = 8 + SCALE_W;
    localparam int SUM_W  = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 1;
    localparam int SH_W   = SUM_W - FRAC_W;
    localparam int LEN_W  = 2 * GRP_W;
    localparam int WALK_W = GRP_W + 1;

    logic [GRP_W-1:0] group_count_reg, group_depth_reg;
    logic             byte_mode_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [GRP_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic             rd_pend_reg, last_pend_reg;

    logic [GRP_W-1:0] rows, cols;
    logic [LEN_W-1:0] grid;
    logic [CNT_W-1:0] len, col_lim;
    logic [CNT_W-1:0] col_inc;
    logic [WALK_W-1:0] idx_step;
    logic             col_end, col_last;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic [SH_W-1:0]   shifted;
    logic [7:0]        byte_res;
    logic [WORD_W-1:0] wr_value;
    logic [WORD_W-1:0] rd_data;

    // Zero group size behaves as one.
    assign rows = (group_count_reg == '0) ? GRP_W'(1) : group_count_reg;
    assign cols = (group_depth_reg == '0) ? GRP_W'(1) : group_depth_reg;
    assign grid = LEN_W'(rows) * LEN_W'(cols);
    assign len  = (grid > LEN_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : grid[CNT_W-1:0];
    // Only columns whose first entry lies below len hold anything.
    assign col_lim = (WALK_W'(cols) < WALK_W'(len)) ? cols[CNT_W-1:0] : len;

    // Requantization (skipped on bypass): min(255, (byte*scale + offset) >> 20).
    assign prod     = PROD_W'(in_value[7:0]) * PROD_W'(requant_scale);
    assign sum      = SUM_W'(prod) + SUM_W'(requant_offset);
    assign shifted  = sum[SUM_W-1:FRAC_W];
    assign byte_res = requant_bypass ? in_value[7:0]
                    : ((shifted > SH_W'(8'hFF)) ? 8'hFF : shifted[7:0]);
    assign wr_value = byte_mode_reg ? {{(WORD_W-8){1'b0}}, byte_res} : in_value;

    assign status.pixel_done = (fill_reg + CNT_W'(1)) == len;

    // Walk down a column while the next entry exists, then move to the next column.
    assign idx_step = WALK_W'(idx_reg) + WALK_W'(cols);
    assign col_end  = (row_reg == rows - GRP_W'(1)) || (idx_step >= WALK_W'(len));
    assign col_last = (col_reg == col_lim - CNT_W'(1));
    assign col_inc  = col_reg + CNT_W'(1);
    assign status.last_read = col_end && col_last;

    always_comb
    begin
        fill_next = fill_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        idx_next  = idx_reg;
        priority if (cmd.cfg_write)
        begin
            fill_next = '0;
        end
        else if (cmd.accept)
        begin
            fill_next = status.pixel_done ? '0 : fill_reg + CNT_W'(1);
        end
        if (cmd.emit_init)
        begin
            row_next = '0;
            col_next = '0;
            idx_next = '0;
        end
        else if (cmd.read)
        begin
            if (col_end)
            begin
                row_next = '0;
                col_next = col_inc;
                idx_next = col_inc[ADDR_W-1:0];
            end
            else
            begin
                row_next = row_reg + GRP_W'(1);
                idx_next = idx_step[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= GRP_W'(1);
            group_depth_reg <= GRP_W'(1);
            byte_mode_reg   <= 1'b0;
            fill_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            last_pend_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                unique case (cfg_index)
                    REG_GROUP_COUNT: group_count_reg <= cfg_data;
                    REG_GROUP_DEPTH: group_depth_reg <= cfg_data;
                    REG_BYTE_MODE:   byte_mode_reg   <= cfg_data[0];
                    default:         ;
                endcase
            end
            // Writes beyond the register list leave the partial pixel alone.
            if (!cmd.cfg_write || cfg_index == REG_GROUP_COUNT
                || cfg_index == REG_GROUP_DEPTH || cfg_index == REG_BYTE_MODE)
            begin
                fill_reg <= fill_next;
            end
            rd_pend_reg   <= cmd.read;
            last_pend_reg <= cmd.read && status.last_read;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        idx_reg <= idx_next;
    end

    cshuf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (wr_value),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign out_valid     = rd_pend_reg;
    assign out_value     = rd_data;
    assign last_of_pixel = last_pend_reg;

endmodule

// ===== rtl/core/channel_shuffle_requant.sv =====
// Top level of the channel shuffle with requantization.
// Depends on cshuf_pkg, cshuf_ctrl, cshuf_dp (which holds cshuf_ram).
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  input     | start & !busy           | in_value, requant_scale, requant_offset,
//            |                         | requant_bypass
//  result    | out_valid (one cycle)   | out_value, last_of_pixel
//  config    | cfg_valid & cfg_ready   | cfg_index, cfg_data
//
// Elements are accepted while busy is low and written to the pixel buffer.
// The transaction that completes a pixel of L elements sets busy while the buffer
// is read once per element; results appear in the cycle after their reads
// (registered RAM port). Emission is paced by the single buffer read port.
// Reset clears the state machine, fill count and config registers; the buffer
// contents are not cleared. Results cannot be stalled.
module channel_shuffle_requant
    import cshuf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [WORD_W-1:0] in_value,
    input  logic [SCALE_W-1:0]       requant_scale,
    input  logic [OFFS_W-1:0]        requant_offset,
    input  logic                     requant_bypass,
    output logic                     out_valid,
    output logic signed [WORD_W-1:0] out_value,
    output logic                     last_of_pixel,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    cmd_t    cmd;
    status_t status;

    cshuf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready)
    );

    cshuf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_value       (in_value),
        .requant_scale  (requant_scale),
        .requant_offset (requant_offset),
        .requant_bypass (requant_bypass),
        .out_valid      (out_valid),
        .out_value      (out_value),
        .last_of_pixel  (last_of_pixel)
    );

endmodule

// ===== rtl/core/cshuf_checker.sv =====
// Port-level checks for channel_shuffle_requant, attached by bind.
// Depends on cshuf_pkg.
module cshuf_checker
    import cshuf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic out_valid,
    input logic last_of_pixel,
    input logic cfg_ready
);

    // Every result comes from a read issued while busy.
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_last_is_result: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_pixel |-> out_valid)
        else $error("last_of_pixel outside a result");

    // Releasing busy coincides with the final result of the pixel.
    a_fall_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> last_of_pixel)
        else $error("busy dropped without the last result");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_pixel |=> !out_valid)
        else $error("result right after the end of a pixel");

    a_cfg_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("config port open during emission");

endmodule

bind channel_shuffle_requant cshuf_checker u_cshuf_checker (.*);

// ===== tb/channel_shuffle_requant_chk.sv =====
`timescale 1ns / 100ps
// Scoreboard for channel_shuffle_requant: tracks the register writes, rebuilds each pixel,
// predicts the transposed results and compares them as they leave the block.
// Depends on cshuf_pkg.
module channel_shuffle_requant_chk
    import cshuf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [WORD_W-1:0] in_value,
    input  logic [SCALE_W-1:0]       requant_scale,
    input  logic [OFFS_W-1:0]        requant_offset,
    input  logic                     requant_bypass,
    input  logic                     out_valid,
    input  logic signed [WORD_W-1:0] out_value,
    input  logic                     last_of_pixel,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    output int                       mismatches,
    output int                       outstanding,
    output int                       results_seen
);

    localparam logic [63:0] BYTE_MAX = 64'hFF;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
    } shuffled_t;

    shuffled_t         shuffled_queue[$];
    logic [WORD_W-1:0] pixel_buf[MAX_CHANNELS];
    int unsigned       fill_level;
    logic [GRP_W-1:0]  rows_reg;
    logic [GRP_W-1:0]  cols_reg;
    logic              byte_reg;

    function automatic logic [WORD_W-1:0] requantize(
        input logic [7:0]         b,
        input logic [SCALE_W-1:0] scale,
        input logic [OFFS_W-1:0]  offs
    );
        logic [63:0] acc;
        acc = 64'(b) * 64'(scale) + 64'(offs);
        acc = acc >> FRAC_W;
        if (acc > BYTE_MAX)
            acc = BYTE_MAX;
        return WORD_W'(acc);
    endfunction

    // Stores one element; on the last one of a pixel, queues the column-major walk.
    task automatic take_element(
        input logic [WORD_W-1:0]  v,
        input logic [SCALE_W-1:0] scale,
        input logic [OFFS_W-1:0]  offs,
        input logic               bypass
    );
        int unsigned       rows;
        int unsigned       cols;
        int unsigned       len;
        int unsigned       idx;
        int unsigned       n;
        logic [WORD_W-1:0] elem;
        shuffled_t         item;
        rows = (rows_reg == '0) ? 1 : int'(rows_reg);
        cols = (cols_reg == '0) ? 1 : int'(cols_reg);
        len  = rows * cols;
        if (len > MAX_CHANNELS)
            len = MAX_CHANNELS;
        elem = v;
        if (byte_reg)
            elem = bypass ? {{(WORD_W-8){1'b0}}, v[7:0]} : requantize(v[7:0], scale, offs);
        if (fill_level >= len)
            fill_level = 0;
        pixel_buf[fill_level] = elem;
        fill_level++;
        if (fill_level < len)
            return;
        n = 0;
        for (int unsigned c = 0; c < cols; c++)
        begin
            for (int unsigned r = 0; r < rows; r++)
            begin
                idx = r * cols + c;
                if (idx < len)
                begin
                    item.value = pixel_buf[idx];
                    item.last  = (n == len - 1);
                    shuffled_queue.push_back(item);
                    n++;
                end
            end
        end
        fill_level = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        shuffled_t want;
        if (!rst_n)
        begin
            shuffled_queue.delete();
            fill_level   = 0;
            rows_reg     = GRP_W'(1);
            cols_reg     = GRP_W'(1);
            byte_reg     = 1'b0;
            mismatches   = 0;
            outstanding  = 0;
            results_seen = 0;
        end
        else
        begin
            if (out_valid)
            begin
                results_seen++;
                if (shuffled_queue.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got value %h last %b",
                             $time, out_value, last_of_pixel);
                end
                else
                begin
                    want = shuffled_queue.pop_front();
                    if (out_value !== want.value)
                    begin
                        mismatches++;
                        $display("%0t: out_value expected %h, got %h",
                                 $time, want.value, out_value);
                    end
                    if (last_of_pixel !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: last_of_pixel expected %b, got %b",
                                 $time, want.last, last_of_pixel);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GROUP_COUNT:
                    begin
                        rows_reg   = cfg_data;
                        fill_level = 0;
                    end
                    REG_GROUP_DEPTH:
                    begin
                        cols_reg   = cfg_data;
                        fill_level = 0;
                    end
                    REG_BYTE_MODE:
                    begin
                        byte_reg   = cfg_data[0];
                        fill_level = 0;
                    end
                    default: ;  // unmapped index: no effect, partial pixel kept
                endcase
            end
            if (start && !busy)
                take_element(in_value, requant_scale, requant_offset, requant_bypass);
            outstanding = shuffled_queue.size();
        end
    end

endmodule

// ===== tb/channel_shuffle_requant_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for channel_shuffle_requant: drives elements and register writes
// and reports the verdict. Depends on cshuf_pkg, the block and channel_shuffle_requant_chk.
module channel_shuffle_requant_tb;
    import cshuf_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int ELEMENT_TARGET = 420;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [WORD_W-1:0] in_value;
    logic [SCALE_W-1:0]       requant_scale;
    logic [OFFS_W-1:0]        requant_offset;
    logic                     requant_bypass;
    logic                     out_valid;
    logic signed [WORD_W-1:0] out_value;
    logic                     last_of_pixel;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]         cfg_data;

    int mismatches;
    int outstanding;
    int results_seen;
    int cycle_count = 0;
    int elements_sent;
    int settings_used;
    int burst_left;
    int pixel_len;

    channel_shuffle_requant DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .in_value       (in_value),
        .requant_scale  (requant_scale),
        .requant_offset (requant_offset),
        .requant_bypass (requant_bypass),
        .out_valid      (out_valid),
        .out_value      (out_value),
        .last_of_pixel  (last_of_pixel),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    channel_shuffle_requant_chk shuffle_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .in_value       (in_value),
        .requant_scale  (requant_scale),
        .requant_offset (requant_offset),
        .requant_bypass (requant_bypass),
        .out_valid      (out_valid),
        .out_value      (out_value),
        .last_of_pixel  (last_of_pixel),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_seen   (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("channel_shuffle_requant regression: fail");
            $finish;
        end
    end

    function automatic int grid_len(input logic [CFG_W-1:0] gc, input logic [CFG_W-1:0] gd);
        int p;
        p = ((gc == '0) ? 1 : int'(gc)) * ((gd == '0) ? 1 : int'(gd));
        return (p > MAX_CHANNELS) ? MAX_CHANNELS : p;
    endfunction

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic push_element(
        input logic [WORD_W-1:0]  v,
        input logic [SCALE_W-1:0] scale,
        input logic [OFFS_W-1:0]  offs,
        input logic               bypass
    );
        @(negedge clk);
        start          <= 1'b1;
        in_value       <= v;
        requant_scale  <= scale;
        requant_offset <= offs;
        requant_bypass <= bypass;
        @(posedge clk);
        while (busy) @(posedge clk);
        elements_sent++;
    endtask

    // Bursts of back-to-back transactions separated by random gaps.
    task automatic send_element(
        input logic [WORD_W-1:0]  v,
        input logic [SCALE_W-1:0] scale,
        input logic [OFFS_W-1:0]  offs,
        input logic               bypass
    );
        if (burst_left <= 0)
        begin
            pause_sender($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
        end
        push_element(v, scale, offs, bypass);
        burst_left--;
    endtask

    task automatic send_random_element();
        logic [SCALE_W-1:0] scale;
        logic [OFFS_W-1:0]  offs;
        case ($urandom_range(0, 5))
            0:       scale = '1;
            1:       scale = '0;
            default: scale = SCALE_W'($urandom);
        endcase
        // small offsets keep most requantized bytes off the saturation limit
        if ($urandom_range(0, 3) == 0)
            offs = OFFS_W'($urandom);
        else
            offs = OFFS_W'($urandom_range(0, 1 << (FRAC_W + 1)));
        send_element($urandom, scale, offs, $urandom_range(0, 3) == 0);
    endtask

    task automatic drain_results();
        pause_sender(1);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(
        input logic [CFG_W-1:0] gc,
        input logic [CFG_W-1:0] gd,
        input logic             bm
    );
        drain_results();
        write_reg(REG_GROUP_COUNT, gc);
        write_reg(REG_GROUP_DEPTH, gd);
        write_reg(REG_BYTE_MODE, CFG_W'(bm));
        pixel_len = grid_len(gc, gd);
        settings_used++;
    endtask

    task automatic send_pixels(input int count);
        repeat (count * pixel_len)
        begin
            send_random_element();
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] gc;
        logic [CFG_W-1:0] gd;
        int               n_pix;

        rst_n          <= 1'b0;
        start          <= 1'b0;
        in_value       <= '0;
        requant_scale  <= '0;
        requant_offset <= '0;
        requant_bypass <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_GROUP_COUNT;
        cfg_data       <= '0;
        elements_sent  = 0;
        settings_used  = 1;
        burst_left     = 0;
        pixel_len      = 1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: 1x1 word mode, requant fields ignored
        send_element(32'h7FFF_FFFF, '1, '1, 1'b0);
        send_element(32'h8000_0000, '1, '0, 1'b1);
        send_element(32'hFFFF_FFFF, '0, '1, 1'b0);
        send_element(32'h0000_0000, '0, '0, 1'b1);

        // byte mode: saturation, zero, bypass, truncation edges
        configure(CFG_W'(2), CFG_W'(3), 1'b1);
        send_element(32'h0000_00FF, '1, '1, 1'b0);
        send_element(32'h0000_0000, '0, '0, 1'b0);
        send_element(32'hABCD_E123, '0, '0, 1'b1);
        send_element(32'h0000_0080, '1, '0, 1'b0);
        send_element(32'hFFFF_FF01, SCALE_W'(1 << (FRAC_W - 1)),
                     OFFS_W'(1 << (FRAC_W - 1)), 1'b0);
        send_element(32'h7FFF_FFFF, '0, '1, 1'b0);

        // register write drops a partial pixel
        send_random_element();
        send_random_element();
        drain_results();
        write_reg(REG_GROUP_DEPTH, CFG_W'(2));
        repeat (4) send_random_element();

        // unmapped index must leave the partial pixel alone
        send_random_element();
        send_random_element();
        drain_results();
        write_reg(REG_UNUSED, CFG_W'($urandom));
        send_random_element();
        send_random_element();

        // zero sizes act as one
        configure(CFG_W'(0), CFG_W'(0), 1'b0);
        send_random_element();
        send_random_element();

        // full-width sizes, oversized grid with skipped positions, single row of 64
        configure(CFG_W'(127), CFG_W'(127), 1'b0);
        send_pixels(1);
        configure(CFG_W'(3), CFG_W'(30), 1'b1);
        send_pixels(1);
        configure(CFG_W'(0), CFG_W'(64), 1'b1);
        send_pixels(1);

        while (elements_sent < ELEMENT_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                gc = CFG_W'($urandom_range(0, 127));
                gd = CFG_W'($urandom_range(0, 127));
            end
            else
            begin
                gc = CFG_W'($urandom_range(0, 8));
                gd = CFG_W'($urandom_range(0, 8));
            end
            configure(gc, gd, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_UNUSED, CFG_W'($urandom));
            n_pix = (pixel_len > 16) ? 1 : $urandom_range(1, 5);
            send_pixels(n_pix);
            // leave a partial pixel behind for the next write to discard
            if ($urandom_range(0, 3) == 0 && pixel_len > 1)
                repeat ($urandom_range(1, pixel_len - 1)) send_random_element();
        end

        pause_sender(1);
        while (outstanding != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d elements across %0d register settings (word and byte mode,",
                 elements_sent, settings_used);
        $display("zero, small and oversized groups); %0d shuffled results checked.",
                 results_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("channel_shuffle_requant regression: pass");
        else
            $display("channel_shuffle_requant regression: fail");
        $finish;
    end

endmodule

// ===== channel_shuffle_requant.f =====
rtl/core/cshuf_pkg.sv
rtl/core/cshuf_ram.sv
rtl/core/cshuf_ctrl.sv
rtl/core/cshuf_dp.sv
rtl/core/channel_shuffle_requant.sv
rtl/core/cshuf_checker.sv
tb/channel_shuffle_requant_chk.sv
tb/channel_shuffle_requant_tb.sv
